// ----- rtl/core/sht_pkg.sv -----
// shared types and constants for the search hash table engine
`default_nettype none

package sht_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int FILL_SAMPLE   = 1000;
  localparam int FILL_LIMIT    = (FILL_SAMPLE < TABLE_ENTRIES) ? FILL_SAMPLE : TABLE_ENTRIES;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int WALK_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int FILL_W        = 11;
  localparam int TAG_W         = 32;

  localparam logic [2:0] KIND_SAVE       = 3'd0;
  localparam logic [2:0] KIND_PROBE      = 3'd1;
  localparam logic [2:0] KIND_NEW_SEARCH = 3'd2;
  localparam logic [2:0] KIND_CLEAR      = 3'd3;
  localparam logic [2:0] KIND_FILL       = 3'd4;

  localparam logic [1:0] EXACT_BOUND = 2'd3;

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic signed [15:0] eval;
    logic [15:0]        best_move;
    logic [1:0]         bound;
    logic               is_pv;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic signed [15:0] score;
    logic signed [15:0] eval;
    logic [15:0]        move;
    logic [7:0]         depth;
    logic [2:0]         node;
    logic [7:0]         age;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic signed [15:0] entry_score;
    logic signed [15:0] entry_eval;
    logic [15:0]        entry_move;
    logic [7:0]         entry_depth;
    logic [2:0]         entry_node;
    logic [7:0]         entry_age;
    logic [FILL_W-1:0]  fill_count;
  } result_t;

  typedef struct packed {
    logic accept;
    logic save_wr;
    logic probe_ld;
    logic gen_inc;
    logic clear_wr;
    logic gen_zero;
    logic count_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_last_clear;
    logic walk_last_count;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/search_hash_table_engine.sv -----
// top level: direct-mapped search hash table with depth and age replacement
// save, probe, new search and unknown kinds read the table on accept, then write or load the
// result, then deliver it; a new item is accepted only once the previous result is loaded out
// clear and fill count walk the table one entry a cycle
// reset: synchronous; a clearing pass over all TABLE_ENTRIES (1024) entries follows reset,
// during which no beat is accepted
`default_nettype none

module search_hash_table_engine
  import sht_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // key[63:0], depth[71:64], score[87:72], eval[103:88], best_move[119:104],
  // bound[121:120], is_pv[122], zero pad[127:123]
  input  wire logic [127:0] s_tdata,
  // kind[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // found[0], entry_score[16:1], entry_eval[32:17], entry_move[48:33],
  // entry_depth[56:49], entry_node[59:57], entry_age[67:60], fill_count[78:68], zero[79]
  output logic [79:0]       m_tdata
);

  item_t   item;
  cmd_t    cmd;
  stat_t   stat;
  result_t result;

  always_comb begin
    item.key       = s_tdata[63:0];
    item.depth     = s_tdata[71:64];
    item.score     = s_tdata[87:72];
    item.eval      = s_tdata[103:88];
    item.best_move = s_tdata[119:104];
    item.bound     = s_tdata[121:120];
    item.is_pv     = s_tdata[122];
  end

  sht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  sht_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd      (cmd),
    .m_tready (m_tready),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .result   (result)
  );

  assign m_tdata = {1'b0, result.fill_count, result.entry_age, result.entry_node,
                    result.entry_depth, result.entry_move, result.entry_eval,
                    result.entry_score, result.found};

  // the clearing pass holds off input right after reset
  a_init_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during clearing pass");

  // one item at a time: an accepted beat drops ready on the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while an item is in flight");

  // table writes only happen while an item or the clearing pass is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.save_wr || cmd.clear_wr) |-> !s_tready)
    else $error("table written while idle");

  // fill count never exceeds the sampled entry count
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[78:68] <= FILL_W'(FILL_LIMIT)))
    else $error("fill count above sample size");

endmodule

`default_nettype wire

// ----- rtl/core/sht_ctrl.sv -----
// controller state machine sequencing table access, sweeps and result delivery
`default_nettype none

module sht_ctrl
  import sht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic [2:0] s_tuser,
  input  wire stat_t      stat,
  output logic            s_tready,
  output cmd_t            cmd
);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_CLEAR, ST_COUNT, ST_TAIL, ST_DELIVER
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] kind;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == ST_IDLE) && s_tvalid;
    cmd.save_wr  = (state == ST_EXEC) && (kind == KIND_SAVE);
    cmd.probe_ld = (state == ST_EXEC) && (kind == KIND_PROBE);
    cmd.gen_inc  = (state == ST_EXEC) && (kind == KIND_NEW_SEARCH);
    cmd.clear_wr = (state == ST_INIT) || (state == ST_CLEAR);
    cmd.gen_zero = cmd.clear_wr && stat.walk_last_clear;
    cmd.count_rd = (state == ST_COUNT);
    cmd.out_load = (state == ST_DELIVER) && stat.out_free;
    s_tready     = (state == ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (stat.walk_last_clear) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          priority if (s_tuser == KIND_CLEAR) state_next = ST_CLEAR;
          else if (s_tuser == KIND_FILL) state_next = ST_COUNT;
          else state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_DELIVER;
      ST_CLEAR: begin
        if (stat.walk_last_clear) state_next = ST_DELIVER;
      end
      ST_COUNT: begin
        if (stat.walk_last_count) state_next = ST_TAIL;
      end
      // last sample read lands in this cycle
      ST_TAIL: state_next = ST_DELIVER;
      ST_DELIVER: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      kind  <= KIND_SAVE;
    end else begin
      state <= state_next;
      if (cmd.accept) kind <= s_tuser;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sht_datapath.sv -----
// table memory, generation, sweep counter, fill counter and output register
`default_nettype none

module sht_datapath
  import sht_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire cmd_t  cmd,
  input  wire logic  m_tready,
  output stat_t      stat,
  output logic       m_tvalid,
  output result_t    result
);

  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd;
  item_t              item_q;
  logic [WALK_W-1:0]  walk;
  logic [7:0]         gen;
  logic               acc_en;
  logic [FILL_W-1:0]  cnt;
  result_t            res;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               replace;
  logic [15:0]        save_move;
  logic               live;

  assign stat.walk_last_clear = (walk[IDX_W-1:0] == IDX_W'(TABLE_ENTRIES - 1));
  assign stat.walk_last_count = (walk == WALK_W'(FILL_LIMIT - 1));
  assign stat.out_free        = !m_tvalid || m_tready;

  always_comb begin
    rd_en   = cmd.accept || cmd.count_rd;
    rd_addr = cmd.count_rd ? walk[IDX_W-1:0] : item.key[IDX_W-1:0];

    replace = (item_q.bound == EXACT_BOUND) || (rd.tag != item_q.key[TAG_W-1:0]) ||
              (rd.age != gen) || (rd.depth <= item_q.depth);
    save_move = (item_q.best_move == 16'd0) ? rd.move : item_q.best_move;

    wr_en   = cmd.clear_wr || (cmd.save_wr && replace);
    wr_addr = cmd.clear_wr ? walk[IDX_W-1:0] : item_q.key[IDX_W-1:0];
    wr_data = '0;
    if (!cmd.clear_wr) begin
      wr_data.tag   = item_q.key[TAG_W-1:0];
      wr_data.score = item_q.score;
      wr_data.eval  = item_q.eval;
      wr_data.move  = save_move;
      wr_data.depth = item_q.depth;
      wr_data.node  = {item_q.is_pv, item_q.bound};
      wr_data.age   = gen;
    end

    live = (rd.tag != '0) && (rd.age == gen);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item_q <= item;

    if (cmd.accept) begin
      res <= '0;
    end else if (cmd.probe_ld) begin
      res.found       <= (rd.tag != '0) && (rd.tag == item_q.key[TAG_W-1:0]);
      res.entry_score <= rd.score;
      res.entry_eval  <= rd.eval;
      res.entry_move  <= rd.move;
      res.entry_depth <= rd.depth;
      res.entry_node  <= rd.node;
      res.entry_age   <= rd.age;
    end

    // fill count sits in the lowest bits of the result
    if (cmd.out_load) begin
      result <= {res[$bits(result_t)-1:FILL_W], cnt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk     <= '0;
      gen      <= '0;
      acc_en   <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      acc_en <= cmd.count_rd;

      if (cmd.clear_wr) begin
        walk <= stat.walk_last_clear ? '0 : walk + 1'b1;
      end else if (cmd.count_rd) begin
        walk <= stat.walk_last_count ? '0 : walk + 1'b1;
      end

      // generation wraps naturally at eight bits
      if (cmd.gen_zero) begin
        gen <= '0;
      end else if (cmd.gen_inc) begin
        gen <= gen + 8'd1;
      end

      if (cmd.accept) begin
        cnt <= '0;
      end else if (acc_en && live && (cnt != '1)) begin
        cnt <= cnt + 1'b1;
      end

      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/search_hash_table_engine_test.sv -----
// testbench for the search hash table engine: directed table, then checked random traffic
`default_nettype none

module search_hash_table_engine_test;
  import sht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;
  localparam int FILL_CEILING = 2047;
  localparam int RANDOM_ITEMS = 650;
  localparam int WRAP_RUN     = 256;
  localparam int STALL_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_LIMIT  = 50;

  localparam logic [63:0] KEY_ALL   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_ALIAS = 64'h0000_0000_0000_03FF;
  localparam logic [63:0] KEY_ZERO  = 64'h0;
  localparam logic [63:0] KEY_ONE   = 64'h1234_5678_0000_0001;
  localparam logic [63:0] KEY_TOP   = 64'hFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [2:0] kind;
    item_t      beat;
    logic       typed;
    result_t    want;
  } step_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;

  search_hash_table_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  entry_t      entry_copy [TABLE_ENTRIES];
  logic [7:0]  generation_copy = '0;
  result_t     responses_due [$];
  step_t       directed_steps [$];
  logic [63:0] recent_keys [$];
  int          mismatches = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          rx_hold = 0;
  int          idle_cycles = 0;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) entry_copy[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // shadow of the table: returns the response and updates the copy
  function automatic result_t table_response(input logic [2:0] kind, input item_t b);
    result_t          r;
    logic [IDX_W-1:0] slot;
    entry_t           e;
    logic [15:0]      mv;
    int               n;
    r = '0;
    slot = b.key[IDX_W-1:0];
    e = entry_copy[slot];
    case (kind)
      KIND_SAVE: begin
        mv = (b.best_move == 16'd0) ? e.move : b.best_move;
        if (b.bound == EXACT_BOUND || e.tag != b.key[TAG_W-1:0] ||
            e.age != generation_copy || e.depth <= b.depth) begin
          entry_copy[slot] = {b.key[TAG_W-1:0], b.score, b.eval, mv, b.depth,
                              b.is_pv, b.bound, generation_copy};
        end
      end
      KIND_PROBE: begin
        r.found       = (e.tag != '0) && (e.tag == b.key[TAG_W-1:0]);
        r.entry_score = e.score;
        r.entry_eval  = e.eval;
        r.entry_move  = e.move;
        r.entry_depth = e.depth;
        r.entry_node  = e.node;
        r.entry_age   = e.age;
      end
      KIND_NEW_SEARCH: generation_copy = generation_copy + 8'd1;
      KIND_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) entry_copy[i] = '0;
        generation_copy = '0;
      end
      KIND_FILL: begin
        n = 0;
        for (int i = 0; i < FILL_LIMIT; i++)
          if (entry_copy[i].tag != '0 && entry_copy[i].age == generation_copy) n++;
        r.fill_count = FILL_W'((n > FILL_CEILING) ? FILL_CEILING : n);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t beat_of(input logic [63:0] key, input logic [7:0] depth,
                                    input logic [15:0] score, input logic [15:0] eval,
                                    input logic [15:0] move, input logic [1:0] bound,
                                    input logic pv);
    return {key, depth, score, eval, move, bound, pv};
  endfunction

  task automatic add_row(input logic [2:0] kind, input item_t b, input logic typed,
                         input result_t want);
    directed_steps.push_back({kind, b, typed, want});
  endtask

  // keys crowd a few slots so that tags collide and replacement gets exercised
  function automatic logic [63:0] random_key();
    logic [IDX_W-1:0]       slot;
    logic [TAG_W-IDX_W-1:0] tag_hi;
    case ($urandom_range(0, 3))
      0: slot = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
      1: slot = IDX_W'(TABLE_ENTRIES - 1 - int'($urandom_range(0, 7)));
      default: slot = IDX_W'($urandom_range(0, 7));
    endcase
    tag_hi = (TAG_W-IDX_W)'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2));
    return {$urandom, tag_hi, slot};
  endfunction

  function automatic item_t random_beat();
    item_t b;
    b.key       = random_key();
    b.depth     = 8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
    b.score     = 16'($urandom);
    b.eval      = 16'($urandom);
    b.best_move = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    b.bound     = 2'($urandom_range(0, 3));
    b.is_pv     = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (tx_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_beat(input logic [2:0] kind, input item_t b, input logic typed,
                           input result_t want);
    int      gap;
    result_t r;
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, b.is_pv, b.bound, b.best_move, b.eval, b.score, b.depth, b.key};
    do @(posedge clk); while (!s_tready);
    r = table_response(kind, b);
    responses_due.push_back(typed ? want : r);
  endtask

  // result side: random stalls, some long, with calm stretches
  always @(posedge clk) begin
    int roll;
    if ($urandom_range(0, 299) == 0) rx_steady <= !rx_steady;
    roll = $urandom_range(0, 99);
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!rx_steady && roll < 5) begin
      m_tready <= 1'b0;
      rx_hold <= $urandom_range(10, 40);
    end else if (!rx_steady && roll < 30) begin
      m_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tdata[48:33], m_tdata[56:49],
             m_tdata[59:57], m_tdata[67:60], m_tdata[78:68]};
      if (m_tdata[79] !== 1'b0) report_mismatch("pad bit of result beat not zero");
      if (responses_due.size() == 0) begin
        report_mismatch($sformatf("result beat %0h with nothing pending", m_tdata));
      end else begin
        want = responses_due.pop_front();
        check_field("found", 64'(got.found), 64'(want.found));
        check_field("entry_score", 64'(got.entry_score), 64'(want.entry_score));
        check_field("entry_eval", 64'(got.entry_eval), 64'(want.entry_eval));
        check_field("entry_move", 64'(got.entry_move), 64'(want.entry_move));
        check_field("entry_depth", 64'(got.entry_depth), 64'(want.entry_depth));
        check_field("entry_node", 64'(got.entry_node), 64'(want.entry_node));
        check_field("entry_age", 64'(got.entry_age), 64'(want.entry_age));
        check_field("fill_count", 64'(got.fill_count), 64'(want.fill_count));
      end
    end
  end

  // watchdog: the clearing pass and a fill walk are the longest quiet spells
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    step_t       row;
    item_t       b;
    logic [2:0]  kind;
    int          roll;

    // deepest save at the top slot, then shallower and exact saves against it
    add_row(KIND_PROBE, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    add_row(KIND_FILL, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    add_row(KIND_SAVE, beat_of(KEY_ALL, 8'd255, 16'h8000, 16'h7FFF, 16'hFFFF, 2'd2, 1'b1),
            1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b1,
            {1'b1, 16'h8000, 16'h7FFF, 16'hFFFF, 8'd255, 3'd6, 8'd0, 11'd0});
    add_row(KIND_SAVE, beat_of(KEY_ALL, 8'd0, 16'h0001, 16'h0002, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    add_row(KIND_SAVE, beat_of(KEY_ALL, 8'd0, 16'h1111, 16'h2222, 16'h0, EXACT_BOUND, 1'b0),
            1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    // same slot, other tag
    add_row(KIND_SAVE, beat_of(KEY_ALIAS, 8'd0, 16'hABCD, 16'h5432, 16'h0001, 2'd0, 1'b0),
            1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    // zero tag never hits
    add_row(KIND_SAVE, beat_of(KEY_ZERO, 8'd5, 16'h7FFF, 16'h8000, 16'h1234, 2'd1, 1'b1),
            1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    add_row(KIND_SAVE, beat_of(KEY_ONE, 8'd10, 16'h0100, 16'hFF00, 16'h4321, 2'd2, 1'b0),
            1'b1, '0);
    add_row(KIND_FILL, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    // stale age lets a shallow save through
    add_row(KIND_NEW_SEARCH, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0),
            1'b1, '0);
    add_row(KIND_SAVE, beat_of(KEY_ONE, 8'd0, 16'h0200, 16'h0300, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ONE, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    add_row(KIND_FILL, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    add_row(KIND_SPARE_A, beat_of(KEY_ALL, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1),
            1'b1, '0);
    add_row(KIND_SPARE_B, beat_of(KEY_ONE, 8'd1, 16'h1, 16'h1, 16'h1, 2'd1, 1'b0), 1'b1, '0);
    add_row(KIND_SPARE_C, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    add_row(KIND_CLEAR, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_ALL, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b1, '0);
    // equal depth still replaces
    add_row(KIND_SAVE, beat_of(KEY_TOP, 8'd128, 16'h0FF0, 16'hF00F, 16'h00FF, 2'd1, 1'b0),
            1'b1, '0);
    add_row(KIND_SAVE, beat_of(KEY_TOP, 8'd128, 16'h1234, 16'h5678, 16'h0, 2'd1, 1'b0),
            1'b1, '0);
    add_row(KIND_PROBE, beat_of(KEY_TOP, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);
    add_row(KIND_FILL, beat_of(KEY_ZERO, 8'd0, 16'h0, 16'h0, 16'h0, 2'd0, 1'b0), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      send_beat(row.kind, row.beat, row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // one long run of new searches walks the generation through its wrap
      if (n == RANDOM_ITEMS / 2)
        for (int w = 0; w < WRAP_RUN; w++) send_beat(KIND_NEW_SEARCH, random_beat(), 1'b0, '0);
      b = random_beat();
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        kind = KIND_SAVE;
        if (recent_keys.size() != 0 && $urandom_range(0, 2) == 0)
          b.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        recent_keys.push_back(b.key);
        if (recent_keys.size() > 16) void'(recent_keys.pop_front());
      end else if (roll < 85) begin
        kind = KIND_PROBE;
        if (recent_keys.size() != 0 && $urandom_range(0, 9) < 7)
          b.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end else if (roll < 91) begin
        kind = KIND_NEW_SEARCH;
      end else if (roll < 94) begin
        kind = KIND_FILL;
      end else if (roll < 95) begin
        kind = KIND_CLEAR;
      end else begin
        kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
      end
      send_beat(kind, b, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && responses_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
